@@ rtl/llpf_pkg.sv @@
// Constants and the exp coefficient table for the ladder low-pass filter.
// No dependencies; used by ladder_lowpass_filter_top.
`timescale 1ns / 1ps

package llpf_pkg;

	localparam int EXP_TABLE_DEPTH = 256;
	localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);

	localparam logic [19:0] FREQ_SCALE_RESET = 20'd159433;
	localparam logic [17:0] K_3P6_Q16        = 18'd235930;
	localparam logic [17:0] K_1P6_Q16        = 18'd104858;
	localparam logic [16:0] ONE_Q16          = 17'h10000;
	localparam logic [3:0]  DIV_SIX          = 4'd6;
	localparam longint unsigned EXP_C_Q28    = 64'd372118382;

	typedef logic [17:0] exp_tab_t [EXP_TABLE_DEPTH];

	// exp(1.386249 * i / depth) as Q2.16, Taylor series in Q.28
	function automatic logic [17:0] exp_entry(input int unsigned idx);
		longint unsigned y;
		longint unsigned sum;
		longint unsigned term;
		longint unsigned r;
		y    = (EXP_C_Q28 * longint'(idx)) / EXP_TABLE_DEPTH;
		sum  = 64'd1 << 28;
		term = 64'd1 << 28;
		// once a term reaches zero every later term stays zero
		term = ((term * y) >> 28) / 64'd1;  sum += term;
		term = ((term * y) >> 28) / 64'd2;  sum += term;
		term = ((term * y) >> 28) / 64'd3;  sum += term;
		term = ((term * y) >> 28) / 64'd4;  sum += term;
		term = ((term * y) >> 28) / 64'd5;  sum += term;
		term = ((term * y) >> 28) / 64'd6;  sum += term;
		term = ((term * y) >> 28) / 64'd7;  sum += term;
		term = ((term * y) >> 28) / 64'd8;  sum += term;
		term = ((term * y) >> 28) / 64'd9;  sum += term;
		term = ((term * y) >> 28) / 64'd10; sum += term;
		term = ((term * y) >> 28) / 64'd11; sum += term;
		term = ((term * y) >> 28) / 64'd12; sum += term;
		term = ((term * y) >> 28) / 64'd13; sum += term;
		term = ((term * y) >> 28) / 64'd14; sum += term;
		term = ((term * y) >> 28) / 64'd15; sum += term;
		term = ((term * y) >> 28) / 64'd16; sum += term;
		term = ((term * y) >> 28) / 64'd17; sum += term;
		term = ((term * y) >> 28) / 64'd18; sum += term;
		term = ((term * y) >> 28) / 64'd19; sum += term;
		term = ((term * y) >> 28) / 64'd20; sum += term;
		term = ((term * y) >> 28) / 64'd21; sum += term;
		term = ((term * y) >> 28) / 64'd22; sum += term;
		term = ((term * y) >> 28) / 64'd23; sum += term;
		term = ((term * y) >> 28) / 64'd24; sum += term;
		term = ((term * y) >> 28) / 64'd25; sum += term;
		term = ((term * y) >> 28) / 64'd26; sum += term;
		term = ((term * y) >> 28) / 64'd27; sum += term;
		term = ((term * y) >> 28) / 64'd28; sum += term;
		term = ((term * y) >> 28) / 64'd29; sum += term;
		term = ((term * y) >> 28) / 64'd30; sum += term;
		term = ((term * y) >> 28) / 64'd31; sum += term;
		term = ((term * y) >> 28) / 64'd32; sum += term;
		term = ((term * y) >> 28) / 64'd33; sum += term;
		term = ((term * y) >> 28) / 64'd34; sum += term;
		term = ((term * y) >> 28) / 64'd35; sum += term;
		term = ((term * y) >> 28) / 64'd36; sum += term;
		term = ((term * y) >> 28) / 64'd37; sum += term;
		term = ((term * y) >> 28) / 64'd38; sum += term;
		term = ((term * y) >> 28) / 64'd39; sum += term;
		term = ((term * y) >> 28) / 64'd40; sum += term;
		r = (sum + 64'd2048) >> 12;
		return r[17:0];
	endfunction

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t t;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			t[i] = exp_entry(i);
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

@@ rtl/ladder_lowpass_filter_top.sv @@
// Four-stage ladder low-pass filter with resonance feedback and soft clip.
// Uses llpf_pkg for constants and the exp table.
`timescale 1ns / 1ps

// Usage:
// - Input channel in_valid/in_ready carries sample_in, cutoff_hz and resonance;
//   output channel out_valid/out_ready carries sample_out. One result per item.
// - cfg_we writes cfg_data into freq_scale; write only while the block is idle.
// - All products go through one shift-add multiplier that consumes one
//   multiplier bit per cycle and stops early once the remaining bits are zero.
//   Sixteen products per item plus a bit-serial divide by six for the soft clip.
// - One item is in work at a time; a new item is taken only once the block
//   is back in its idle step.
// - A finished result sits in the output register; the next item is taken
//   while it waits. If the receiver still stalls when the following result is
//   ready, the block holds it in its last step until the register frees.
// - Reset clears all filter state to zero and freq_scale to its default.

module ladder_lowpass_filter_top #(
	parameter int STATE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [19:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sample_in,
	input  logic [15:0]        cutoff_hz,
	input  logic [15:0]        resonance,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample_out
);

	localparam int W   = STATE_WIDTH;
	localparam int F   = W - 4;
	localparam int PW  = 2 * W + 3;
	localparam int XW  = PW + 2;
	localparam int CW  = W + 6;
	localparam int DCW = $clog2(CW + 1);

	localparam logic signed [XW-1:0] SMAX = {{(XW - W + 1){1'b0}}, {(W - 1){1'b1}}};
	localparam logic signed [XW-1:0] SMIN = ~SMAX;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ISSUE = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_RES   = 3'd3;
	localparam logic [2:0] ST_WB    = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_S4    = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	localparam logic [3:0] OP_FCON = 4'd0;
	localparam logic [3:0] OP_F2   = 4'd1;
	localparam logic [3:0] OP_A    = 4'd2;
	localparam logic [3:0] OP_B    = 4'd3;
	localparam logic [3:0] OP_K    = 4'd4;
	localparam logic [3:0] OP_XN   = 4'd5;
	localparam logic [3:0] OP_SA   = 4'd6;
	localparam logic [3:0] OP_SB   = 4'd7;
	localparam logic [3:0] OP_C1   = 4'd8;
	localparam logic [3:0] OP_C2   = 4'd9;

	localparam logic [1:0] SH_T16 = 2'd0;
	localparam logic [1:0] SH_R16 = 2'd1;
	localparam logic [1:0] SH_R14 = 2'd2;
	localparam logic [1:0] SH_RF  = 2'd3;

	// control
	logic [2:0]     state_q;
	logic [3:0]     op_q;
	logic [1:0]     sidx_q;
	logic [DCW-1:0] div_cnt_q;
	logic           out_valid_q;
	logic [19:0]    freq_scale_q;
	logic signed [W-1:0] prev_q [4];
	logic signed [W-1:0] stg_q [4];

	// datapath
	logic signed [15:0] sample_q;
	logic [15:0]        cutoff_q;
	logic [15:0]        res_q;
	logic [PW-1:0]      mul_a_q;
	logic [W-1:0]       mul_b_q;
	logic [PW-1:0]      acc_q;
	logic               mul_neg_q;
	logic [1:0]         mul_sh_q;
	logic signed [XW-1:0] mres_q;
	logic [PW:0]        mag_q;
	logic [16:0]        fcon_q;
	logic [16:0]        f2_q;
	logic [17:0]        t_q;
	logic signed [18:0] kp_q;
	logic [16:0]        pp1d2_q;
	logic [20:0]        k_q;
	logic signed [W-1:0] cur_q;
	logic signed [W+1:0] tmp_q;
	logic signed [W-1:0] y4_q;
	logic [W+2:0]       p1_q;
	logic [CW-1:0]      div_q;
	logic [2:0]         rem_q;
	logic               cube_neg_q;
	logic signed [15:0] sample_out_q;

	function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
		logic signed [W-1:0] r;
		if (v > SMAX) begin
			r = SMAX[W-1:0];
		end else if (v < SMIN) begin
			r = SMIN[W-1:0];
		end else begin
			r = v[W-1:0];
		end
		return r;
	endfunction

	function automatic logic [W-1:0] abs_w(input logic signed [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	// operand preparation
	logic signed [W:0]   sum_s;
	logic [W:0]          sum_mag;
	logic [W-1:0]        y_mag;
	logic [W-1:0]        y4_mag;
	logic [W-1:0]        s4_mag;
	logic [18:0]         kp_mag;
	logic [16:0]         tab_dif;
	logic [llpf_pkg::IDX_W-1:0] tab_idx;
	logic [17:0]         exp_val;
	logic [PW-1:0]       iss_a;
	logic [W-1:0]        iss_b;
	logic                iss_neg;
	logic [1:0]          iss_sh;

	assign sum_s   = {cur_q[W-1], cur_q} + {prev_q[sidx_q][W-1], prev_q[sidx_q]};
	assign sum_mag = sum_s[W] ? (~sum_s + 1'b1) : sum_s;
	assign y_mag   = abs_w(stg_q[sidx_q]);
	assign y4_mag  = abs_w(y4_q);
	assign s4_mag  = abs_w(stg_q[3]);
	assign kp_mag  = kp_q[18] ? (~kp_q + 1'b1) : kp_q;
	assign tab_dif = llpf_pkg::ONE_Q16 - pp1d2_q;
	// index saturates only when pp1d2 is zero
	assign tab_idx = tab_dif[16] ? {llpf_pkg::IDX_W{1'b1}}
	                             : tab_dif[15 -: llpf_pkg::IDX_W];
	assign exp_val = llpf_pkg::EXP_TAB[tab_idx];

	always_comb begin
		iss_a   = '0;
		iss_b   = '0;
		iss_neg = 1'b0;
		iss_sh  = SH_R16;
		case (op_q)
			OP_FCON: begin
				iss_a  = PW'(freq_scale_q);
				iss_b  = W'(cutoff_q);
				iss_sh = SH_T16;
			end
			OP_F2: begin
				iss_a = PW'(fcon_q);
				iss_b = W'(fcon_q);
			end
			OP_A: begin
				iss_a = PW'(llpf_pkg::K_3P6_Q16);
				iss_b = W'(fcon_q);
			end
			OP_B: begin
				iss_a = PW'(llpf_pkg::K_1P6_Q16);
				iss_b = W'(f2_q);
			end
			OP_K: begin
				iss_a  = PW'(exp_val);
				iss_b  = W'(res_q);
				iss_sh = SH_R14;
			end
			OP_XN: begin
				iss_a   = PW'(s4_mag);
				iss_b   = W'(k_q);
				iss_neg = stg_q[3][W-1];
			end
			OP_SA: begin
				iss_a   = PW'(sum_mag);
				iss_b   = W'(pp1d2_q);
				iss_neg = sum_s[W];
			end
			OP_SB: begin
				iss_a   = PW'(y_mag);
				iss_b   = W'(kp_mag);
				iss_neg = stg_q[sidx_q][W-1] ^ kp_q[18];
			end
			OP_C1: begin
				iss_a  = PW'(y4_mag);
				iss_b  = y4_mag;
				iss_sh = SH_RF;
			end
			OP_C2: begin
				iss_a   = PW'(p1_q);
				iss_b   = y4_mag;
				iss_neg = y4_q[W-1];
				iss_sh  = SH_RF;
			end
			default: begin
				iss_a = '0;
			end
		endcase
	end

	// shift of the finished product, rounded or truncated
	logic [PW:0]         acc_x;
	logic [PW:0]         mag_c;
	logic signed [XW-1:0] res_c;

	assign acc_x = {1'b0, acc_q};

	always_comb begin
		case (mul_sh_q)
			SH_T16:  mag_c = acc_x >> 16;
			SH_R16:  mag_c = (acc_x + (PW + 1)'(1 << 15)) >> 16;
			SH_R14:  mag_c = (acc_x + (PW + 1)'(1 << 13)) >> 14;
			SH_RF:   mag_c = (acc_x + ((PW + 1)'(1) << (F - 1))) >> F;
			default: mag_c = acc_x;
		endcase
		res_c = $signed({1'b0, mag_c});
		if (mul_neg_q) begin
			res_c = -res_c;
		end
	end

	// writeback arithmetic
	logic signed [XW-1:0] smp_x;
	logic signed [W-1:0]  xn_c;
	logic signed [W-1:0]  sec_c;
	logic signed [19:0]   pp_s;
	logic [18:0]          pp_half;
	logic signed [XW-1:0] q_s;
	logic signed [W-1:0]  s4_c;
	logic signed [W:0]    o_add;
	logic signed [W:0]    o_sh;
	logic signed [15:0]   o_c;
	logic [3:0]           div_tr;
	logic                 div_ge;

	assign smp_x   = $signed({{(XW - 16){sample_q[15]}}, sample_q}) <<< (F - 15);
	assign xn_c    = sat_w(smp_x - mres_q);
	assign sec_c   = sat_w($signed({{(XW - W - 2){tmp_q[W+1]}}, tmp_q}) - mres_q);
	assign pp_s    = $signed({2'b00, t_q}) - $signed({2'b00, mag_q[17:0]});
	assign pp_half = pp_s[19:1];
	assign q_s     = cube_neg_q ? -$signed(XW'(div_q)) : $signed(XW'(div_q));
	assign s4_c    = sat_w($signed({{(XW - W){y4_q[W-1]}}, y4_q}) - q_s);
	assign o_add   = {stg_q[3][W-1], stg_q[3]} + $signed((W + 1)'(1) << (F - 16));
	assign o_sh    = o_add >>> (F - 15);
	assign div_tr  = {rem_q, div_q[CW-1]};
	assign div_ge  = div_tr >= llpf_pkg::DIV_SIX;

	always_comb begin
		if (o_sh > $signed((W + 1)'(32767))) begin
			o_c = 16'sh7FFF;
		end else if (o_sh < -$signed((W + 1)'(32768))) begin
			o_c = -16'sh8000;
		end else begin
			o_c = o_sh[15:0];
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_FCON;
			sidx_q       <= '0;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
			freq_scale_q <= llpf_pkg::FREQ_SCALE_RESET;
			for (int i = 0; i < 4; i++) begin
				prev_q[i] <= '0;
				stg_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				freq_scale_q <= cfg_data;
			end
			if (state_q == ST_FIN && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_ISSUE;
						op_q    <= OP_FCON;
						sidx_q  <= '0;
					end
				end
				ST_ISSUE: state_q <= ST_MUL;
				ST_MUL: begin
					if (mul_b_q == '0) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: state_q <= ST_WB;
				ST_WB: begin
					state_q <= ST_ISSUE;
					case (op_q)
						OP_FCON: op_q <= OP_F2;
						OP_F2:   op_q <= OP_A;
						OP_A:    op_q <= OP_B;
						OP_B:    op_q <= OP_K;
						OP_K:    op_q <= OP_XN;
						OP_XN:   op_q <= OP_SA;
						OP_SA:   op_q <= OP_SB;
						OP_SB: begin
							prev_q[sidx_q] <= cur_q;
							if (sidx_q == 2'd3) begin
								op_q <= OP_C1;
							end else begin
								stg_q[sidx_q] <= sec_c;
								sidx_q        <= sidx_q + 2'd1;
								op_q          <= OP_SA;
							end
						end
						OP_C1:   op_q <= OP_C2;
						OP_C2: begin
							state_q   <= ST_DIV;
							div_cnt_q <= '0;
						end
						default: op_q <= OP_FCON;
					endcase
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DCW'(CW - 1)) begin
						state_q <= ST_S4;
					end
				end
				ST_S4: begin
					stg_q[3] <= s4_c;
					state_q  <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sample_q <= sample_in;
				cutoff_q <= cutoff_hz;
				res_q    <= resonance;
			end
			ST_ISSUE: begin
				mul_a_q   <= iss_a;
				mul_b_q   <= iss_b;
				mul_neg_q <= iss_neg;
				mul_sh_q  <= iss_sh;
				acc_q     <= '0;
			end
			ST_MUL: begin
				if (mul_b_q[0]) begin
					acc_q <= acc_q + mul_a_q;
				end
				mul_a_q <= mul_a_q << 1;
				mul_b_q <= mul_b_q >> 1;
			end
			ST_RES: begin
				mres_q <= res_c;
				mag_q  <= mag_c;
			end
			ST_WB: begin
				case (op_q)
					OP_FCON: fcon_q <= (mag_q > (PW + 1)'(llpf_pkg::ONE_Q16))
					                   ? llpf_pkg::ONE_Q16 : mag_q[16:0];
					OP_F2:   f2_q <= mag_q[16:0];
					OP_A:    t_q <= mag_q[17:0];
					OP_B: begin
						kp_q <= 19'(pp_s - 20'sd65536);
						if (pp_s < 0) begin
							pp1d2_q <= '0;
						end else if (pp_half > 19'(llpf_pkg::ONE_Q16)) begin
							pp1d2_q <= llpf_pkg::ONE_Q16;
						end else begin
							pp1d2_q <= pp_half[16:0];
						end
					end
					OP_K:    k_q <= mag_q[20:0];
					OP_XN:   cur_q <= xn_c;
					OP_SA:   tmp_q <= mres_q[W+1:0];
					OP_SB: begin
						if (sidx_q == 2'd3) begin
							y4_q <= sec_c;
						end else begin
							cur_q <= sec_c;
						end
					end
					OP_C1:   p1_q <= mag_q[W+2:0];
					OP_C2: begin
						div_q      <= mag_q[CW-1:0];
						cube_neg_q <= mul_neg_q;
						rem_q      <= '0;
					end
					default: p1_q <= p1_q;
				endcase
			end
			ST_DIV: begin
				rem_q <= div_ge ? 3'(div_tr - llpf_pkg::DIV_SIX) : div_tr[2:0];
				div_q <= {div_q[CW-2:0], div_ge};
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					sample_out_q <= o_c;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_ISSUE && op_q == OP_FCON))
		else $error("accepted item did not start the sequence");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FIN && state_q == ST_IDLE))
		else $error("result presented outside the final step");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_cnt_q < DCW'(CW)))
		else $error("divider ran past its width");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(sample_out_q))
		else $error("waiting result overwritten");

endmodule
